// ===== sv/wrq_pkg.sv =====
// ----------------------------------------------------------------------------
// wrq_pkg
// Types, request codes and controller commands shared by the word ring
// queue with remove.
// ----------------------------------------------------------------------------
package wrq_pkg;

    // default ring capacity in words
    localparam int DEPTH_DEFAULT = 16;

    // field widths of one item and one result
    localparam int REQ_W    = 3;
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 4;
    localparam int COUNT_W  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

    // input item
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [WORD_W-1:0]   word_value;
        logic [OFFSET_W-1:0] offset;
    } req_item_t;

    // result item
    typedef struct packed {
        logic                ok;
        logic [WORD_W-1:0]   read_word;
        logic [COUNT_W-1:0]  removed_count;
        logic [COUNT_W-1:0]  occupancy;
    } rsp_item_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE
    } state_t;

    // datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_CLEAR,
        ACT_NOP,
        ACT_READ_ISSUE,
        ACT_READ_DONE,
        ACT_RM_START,
        ACT_RM_STEP,
        ACT_RM_DONE
    } act_t;

    // controller to datapath
    typedef struct packed {
        act_t act;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rm_done;
    } status_t;

endpackage

// ===== sv/wrq_if.sv =====
// ----------------------------------------------------------------------------
// wrq_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface wrq_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/wrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrq_ctrl
// Controller: sequences push, clear, read, and remove compaction, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module wrq_ctrl
    import wrq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req_type,
    output logic             out_valid,
    input  logic             out_ready,
    output cmd_t             cmd,
    input  status_t          status
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and result flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.act      = ACT_NONE;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    case (req_type)
                        REQ_PUSH:
                        begin
                            cmd.act      = ACT_PUSH;
                            cmd.out_load = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.act      = ACT_CLEAR;
                            cmd.out_load = 1'b1;
                        end
                        REQ_POP, REQ_PEEK, REQ_READ:
                        begin
                            cmd.act    = ACT_READ_ISSUE;
                            state_next = ST_READ;
                        end
                        REQ_REMOVE:
                        begin
                            cmd.act    = ACT_RM_START;
                            state_next = ST_REMOVE;
                        end
                        default:
                        begin
                            cmd.act      = ACT_NOP;
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.act      = ACT_READ_DONE;
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_REMOVE:
            begin
                if (status.rm_done)
                begin
                    cmd.act      = ACT_RM_DONE;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.act = ACT_RM_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/wrq_datapath.sv =====
// ----------------------------------------------------------------------------
// wrq_datapath
// Ring store, pointers, fill count, remove compaction counters and the
// result register.
// ----------------------------------------------------------------------------
module wrq_datapath
    import wrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output status_t   status,
    input  req_item_t req,
    output rsp_item_t rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;

    // ring store
    logic [WORD_W-1:0] mem [DEPTH];

    logic [PW-1:0]     head_reg,    head_next;
    logic [PW-1:0]     tail_reg,    tail_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic [PW-1:0]     src_reg,     src_next;
    logic [PW-1:0]     dst_reg,     dst_next;
    logic [CW-1:0]     left_reg,    left_next;
    logic [CW-1:0]     removed_reg, removed_next;
    logic              pend_reg,    pend_next;
    logic [WORD_W-1:0] key_reg,     key_next;
    logic              ok_reg,      ok_next;
    logic              pop_reg,     pop_next;
    logic [WORD_W-1:0] rd_data_reg;
    rsp_item_t         rsp_reg,     rsp_next;

    logic              we;
    logic [PW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              rd_en;
    logic [PW-1:0]     raddr;

    logic              full;
    logic              empty;
    logic [SW-1:0]     at_sum;
    logic [PW-1:0]     at_addr;
    logic              off_ok;
    logic [CW-1:0]     count_left;

    // wrapping increment
    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // head plus offset, one conditional subtract
    assign at_sum  = SW'(head_reg) + SW'(req.offset);
    assign at_addr = (at_sum >= SW'(DEPTH)) ? PW'(at_sum - SW'(DEPTH)) : PW'(at_sum);
    assign off_ok  = (SW'(req.offset) < SW'(count_reg));

    assign count_left = count_reg - removed_reg;

    assign status.rm_done = (left_reg == '0) && !pend_reg;
    assign rsp            = rsp_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        removed_reg <= removed_next;
        key_reg     <= key_next;
        ok_reg      <= ok_next;
        pop_reg     <= pop_next;
        rsp_reg     <= rsp_next;
    end

    // store write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // store read port, registered data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // action decode
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        left_next    = left_reg;
        removed_next = removed_reg;
        pend_next    = pend_reg;
        key_next     = key_reg;
        ok_next      = ok_reg;
        pop_next     = pop_reg;
        rsp_next     = rsp_reg;
        we           = 1'b0;
        waddr        = tail_reg;
        wdata        = req.word_value;
        rd_en        = 1'b0;
        raddr        = head_reg;

        case (cmd.act)
            ACT_PUSH:
            begin
                if (!full)
                begin
                    we         = 1'b1;
                    tail_next  = ring_inc(tail_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            ACT_READ_ISSUE:
            begin
                rd_en    = 1'b1;
                pop_next = (req.req_type == REQ_POP);
                if (req.req_type == REQ_READ)
                begin
                    raddr   = at_addr;
                    ok_next = off_ok;
                end
                else
                begin
                    ok_next = !empty;
                end
            end
            ACT_READ_DONE:
            begin
                if (pop_reg && ok_reg)
                begin
                    head_next  = ring_inc(head_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_RM_START:
            begin
                key_next     = req.word_value;
                src_next     = head_reg;
                dst_next     = head_reg;
                left_next    = count_reg;
                removed_next = '0;
                pend_next    = 1'b0;
            end
            ACT_RM_STEP:
            begin
                // check the word read last cycle
                if (pend_reg)
                begin
                    if (rd_data_reg == key_reg)
                    begin
                        removed_next = removed_reg + CW'(1);
                    end
                    else
                    begin
                        we       = 1'b1;
                        waddr    = dst_reg;
                        wdata    = rd_data_reg;
                        dst_next = ring_inc(dst_reg);
                    end
                end
                // fetch the next word
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    raddr     = src_reg;
                    src_next  = ring_inc(src_reg);
                    left_next = left_reg - CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ACT_RM_DONE:
            begin
                tail_next  = dst_reg;
                count_next = count_left;
            end
            default:
            begin
            end
        endcase

        // result item
        if (cmd.out_load)
        begin
            rsp_next.ok            = 1'b0;
            rsp_next.read_word     = '0;
            rsp_next.removed_count = '0;
            rsp_next.occupancy     = COUNT_W'(count_next);
            case (cmd.act)
                ACT_PUSH:
                begin
                    rsp_next.ok = !full;
                end
                ACT_CLEAR:
                begin
                    rsp_next.ok = 1'b1;
                end
                ACT_READ_DONE:
                begin
                    rsp_next.ok = ok_reg;
                    if (ok_reg)
                    begin
                        rsp_next.read_word = rd_data_reg;
                    end
                end
                ACT_RM_DONE:
                begin
                    rsp_next.ok            = 1'b1;
                    rsp_next.removed_count = COUNT_W'(removed_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/word_ring_queue_with_remove.sv =====
// Push, clear and unknown codes load the result register on acceptance; pop, peek
// and read at offset first read the store (registered read), then load the result.
// Remove on an empty queue goes straight to its finish step; else it takes one stored
// word per cycle through the single read port, then a last compare and a finish step.
// A new item is taken only when the last one is done and the result register is free.
// Reset: asynchronous, active low; empties the queue, store contents undefined.
// ----------------------------------------------------------------------------
// word_ring_queue_with_remove
// Fixed-depth ring queue of words with push, pop, peek, clear, remove by key
// and read at offset, built from a controller and a datapath.
// ----------------------------------------------------------------------------
module word_ring_queue_with_remove
    import wrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    wrq_if.sink   request,
    wrq_if.source response
);

    cmd_t      cmd;
    status_t   status;
    req_item_t req;
    rsp_item_t rsp;

    assign req           = request.data;
    assign response.data = rsp;

    // sequencing
    wrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .req_type  (req.req_type),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // store and pointers
    wrq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule
